### design/rplc_pkg.sv
// ----------------------------------------------------------------------------
// rplc_pkg
// Types and constants shared by the row page LRU cache modules.
// ----------------------------------------------------------------------------
package rplc_pkg;

    localparam int ROW_W       = 31;
    localparam int PAGE_W      = 31;
    localparam int OFFSET_W    = 16;
    localparam int SLOT_W      = 3;
    localparam int PAGE_SIZE_W = 17;

    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RST = 17'd256;
    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_MIN = 17'd1;
    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_MAX = 17'd65536;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [ROW_W-1:0]  row_num;
    } t_cmd;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [PAGE_W-1:0]   page_number;
        logic [OFFSET_W-1:0] page_ofs;
        logic                evicted;
        logic [PAGE_W-1:0]   evicted_page;
    } t_res;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [PAGE_W-1:0] evicted_page;
    } t_lru_res;

endpackage

### design/rplc_div.sv
// ----------------------------------------------------------------------------
// rplc_div
// Restoring divider: one quotient bit per cycle, row index by page size.
// ----------------------------------------------------------------------------
module rplc_div #(
    parameter int ROW_BITS = 31
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ROW_BITS-1:0]             i_dividend,
    input  logic [rplc_pkg::PAGE_SIZE_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [ROW_BITS-1:0]             o_quotient,
    output logic [rplc_pkg::OFFSET_W-1:0]   o_remainder
);
    import rplc_pkg::*;

    localparam int CNT_W = $clog2(ROW_BITS + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [ROW_BITS-1:0]    r_quo;
    logic [PAGE_SIZE_W-1:0] r_rem;
    logic [PAGE_SIZE_W-1:0] r_div;

    logic [PAGE_SIZE_W:0]   n_shift;
    logic                   n_ge;

    assign n_shift = {r_rem, r_quo[ROW_BITS-1]};
    assign n_ge    = n_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROW_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ROW_BITS-2:0], n_ge};
            if (n_ge) begin
                r_rem <= PAGE_SIZE_W'(n_shift - {1'b0, r_div});
            end else begin
                r_rem <= n_shift[PAGE_SIZE_W-1:0];
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[OFFSET_W-1:0];

endmodule

### design/rplc_lru.sv
// ----------------------------------------------------------------------------
// rplc_lru
// Fully associative page table with LRU ranks, scanned one entry per cycle.
// ----------------------------------------------------------------------------
module rplc_lru #(
    parameter int CACHE_PAGES = 8,
    parameter int PAGE_BITS   = 31
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_flush,
    input  logic                 i_start,
    input  logic [PAGE_BITS-1:0] i_page,
    output logic                 o_done,
    output rplc_pkg::t_lru_res   o_res
);
    import rplc_pkg::*;

    localparam int IW = $clog2(CACHE_PAGES);

    typedef enum logic [1:0] {
        L_IDLE,
        L_SCAN,
        L_DRAIN,
        L_UPDATE
    } t_state;

    t_state               r_state;
    logic                 r_valid [CACHE_PAGES];
    logic [IW-1:0]        r_rank  [CACHE_PAGES];
    logic [PAGE_BITS-1:0] r_mem   [CACHE_PAGES];
    logic [PAGE_BITS-1:0] r_page;
    logic [IW-1:0]        r_addr;
    logic                 r_rd_act;
    logic [IW-1:0]        r_rd_idx;
    logic [PAGE_BITS-1:0] r_rd_data;
    logic                 r_found;
    logic [IW-1:0]        r_hit_idx;
    logic                 r_free_found;
    logic [IW-1:0]        r_free_idx;
    logic                 r_vic_set;
    logic [IW-1:0]        r_vic_idx;
    logic [IW-1:0]        r_vic_rank;
    logic [PAGE_BITS-1:0] r_vic_page;
    logic                 r_done;
    t_lru_res             r_res;

    logic                 n_v;
    logic [IW-1:0]        n_rk_scan;
    logic [IW-1:0]        n_k;
    logic [IW-1:0]        n_rk;
    logic                 n_all_inc;
    logic                 n_evict;
    logic                 n_wr;

    assign n_v       = r_valid[r_rd_idx];
    assign n_rk_scan = r_rank[r_rd_idx];
    assign n_all_inc = !r_found && r_free_found;
    assign n_evict   = !r_found && !r_free_found;
    assign n_k       = r_found ? r_hit_idx : (r_free_found ? r_free_idx : r_vic_idx);
    assign n_rk      = r_found ? r_rank[r_hit_idx] : r_vic_rank;
    assign n_wr      = (r_state == L_UPDATE) && !r_found;

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[n_k] <= i_page;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= L_IDLE;
            r_rd_act <= 1'b0;
            r_done   <= 1'b0;
            for (int i = 0; i < CACHE_PAGES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
        end else begin
            r_done   <= 1'b0;
            r_rd_act <= (r_state == L_SCAN);
            r_rd_idx <= r_addr;

            if (r_rd_act) begin
                if (n_v && (r_rd_data == r_page) && !r_found) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
                if (!n_v && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_rd_idx;
                end
                if (n_v && (!r_vic_set || (n_rk_scan > r_vic_rank))) begin
                    r_vic_set  <= 1'b1;
                    r_vic_idx  <= r_rd_idx;
                    r_vic_rank <= n_rk_scan;
                    r_vic_page <= r_rd_data;
                end
            end

            case (r_state)
                L_IDLE: begin
                    if (i_flush) begin
                        for (int i = 0; i < CACHE_PAGES; i++) begin
                            r_valid[i] <= 1'b0;
                            r_rank[i]  <= '0;
                        end
                    end else if (i_start) begin
                        r_page       <= i_page;
                        r_addr       <= '0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_vic_set    <= 1'b0;
                        r_state      <= L_SCAN;
                    end
                end
                L_SCAN: begin
                    if (r_addr == IW'(CACHE_PAGES - 1)) begin
                        r_state <= L_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                L_DRAIN: begin
                    r_state <= L_UPDATE;
                end
                L_UPDATE: begin
                    for (int i = 0; i < CACHE_PAGES; i++) begin
                        if ((IW'(i) != n_k) && r_valid[i] &&
                            (n_all_inc || (r_rank[i] < n_rk))) begin
                            r_rank[i] <= r_rank[i] + 1'b1;
                        end
                    end
                    r_rank[n_k]        <= '0;
                    r_valid[n_k]       <= 1'b1;
                    r_res.hit          <= r_found;
                    r_res.slot         <= SLOT_W'(n_k);
                    r_res.evicted      <= n_evict;
                    r_res.evicted_page <= n_evict ? PAGE_W'(r_vic_page) : '0;
                    r_done             <= 1'b1;
                    r_state            <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### design/row_page_lru_cache.sv
// ----------------------------------------------------------------------------
// row_page_lru_cache
// Row to page lookup with a fully associative LRU page cache.
// ----------------------------------------------------------------------------
// A lookup runs from the accepting edge to the edge that raises o_strobe: the
// divider produces one quotient bit per cycle, then the page table is scanned
// one entry per cycle through its single read port, drained and updated, with
// a registered handover on each side. busy drops at the edge that raises
// o_strobe, so a new lookup is taken only once the previous one has finished.
// A flush is done at the edge that accepts it, clears the page table and
// never raises busy. The result appears on o_res for exactly one cycle with
// o_strobe and cannot be stalled, so the receiver must take every beat.
// Write page_size only while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module row_page_lru_cache #(
    parameter int CACHE_PAGES    = 8,
    parameter int ROW_INDEX_BITS = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  rplc_pkg::t_cmd                   i_cmd,
    output logic                             o_strobe,
    output rplc_pkg::t_res                   o_res,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rplc_pkg::PAGE_SIZE_W-1:0] i_cfg_data
);
    import rplc_pkg::*;

    localparam int RW = (ROW_INDEX_BITS < ROW_W) ? ROW_INDEX_BITS : ROW_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_LRU
    } t_state;

    t_state                 r_state;
    logic [PAGE_SIZE_W-1:0] r_page_size;
    logic [RW-1:0]          r_page;
    logic [OFFSET_W-1:0]    r_offset;
    logic                   r_strobe;
    t_res                   r_res;
    logic                   r_lru_start;

    logic                   n_accept;
    logic                   n_div_start;
    logic                   n_flush;
    logic                   div_done;
    logic [RW-1:0]          div_quo;
    logic [OFFSET_W-1:0]    div_rem;
    logic                   lru_done;
    t_lru_res               lru_res;

    assign busy        = (r_state != S_IDLE);
    assign n_accept    = start && !busy;
    assign n_div_start = n_accept && (i_cmd.opcode == OP_LOOKUP);
    assign n_flush     = n_accept && (i_cmd.opcode == OP_FLUSH);
    assign o_cfg_ready = 1'b1;

    rplc_div #(
        .ROW_BITS (RW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (n_div_start),
        .i_dividend  (i_cmd.row_num[RW-1:0]),
        .i_divisor   (r_page_size),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    rplc_lru #(
        .CACHE_PAGES (CACHE_PAGES),
        .PAGE_BITS   (RW)
    ) u_lru (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (n_flush),
        .i_start (r_lru_start),
        .i_page  (r_page),
        .o_done  (lru_done),
        .o_res   (lru_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_page_size <= PAGE_SIZE_RST;
            r_strobe    <= 1'b0;
            r_lru_start <= 1'b0;
        end else begin
            r_strobe    <= 1'b0;
            r_lru_start <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_data == '0) begin
                    r_page_size <= PAGE_SIZE_MIN;
                end else if (i_cfg_data > PAGE_SIZE_MAX) begin
                    r_page_size <= PAGE_SIZE_MAX;
                end else begin
                    r_page_size <= i_cfg_data;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (n_flush) begin
                        r_res    <= '0;
                        r_strobe <= 1'b1;
                    end else if (n_div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_page      <= div_quo;
                        r_offset    <= div_rem;
                        r_lru_start <= 1'b1;
                        r_state     <= S_LRU;
                    end
                end
                S_LRU: begin
                    if (lru_done) begin
                        r_res.hit          <= lru_res.hit;
                        r_res.slot         <= lru_res.slot;
                        r_res.page_number  <= PAGE_W'(r_page);
                        r_res.page_ofs     <= r_offset;
                        r_res.evicted      <= lru_res.evicted;
                        r_res.evicted_page <= lru_res.evicted_page;
                        r_strobe           <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
